@@ rtl/image_header_sniffer_assert.svh @@
// Assertion macros for the image header sniffer checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef IMAGE_HEADER_SNIFFER_ASSERT_SVH
`define IMAGE_HEADER_SNIFFER_ASSERT_SVH

// Same-cycle implication, reset-qualified.
`define IHS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-qualified.
`define IHS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ihs_pkg.sv @@
// Shared types, codes and the signature classifier for the image header sniffer.
// No dependencies.
package ihs_pkg;

    // Input beat: one file byte plus end-of-file flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic        status;
        logic [2:0]  format;
        logic [31:0] width;
        logic [31:0] height;
    } out_beat_t;

    // Image format codes
    typedef enum logic [2:0] {
        FMT_UNKNOWN = 3'd0,
        FMT_JPEG    = 3'd1,
        FMT_PNG     = 3'd2,
        FMT_GIF     = 3'd3,
        FMT_WEBP    = 3'd4
    } fmt_t;

    // JPEG marker walk phases
    typedef enum logic [2:0] {
        PH_SCAN  = 3'd0,
        PH_MARK  = 3'd1,
        PH_LENHI = 3'd2,
        PH_LENLO = 3'd3,
        PH_SKIP  = 3'd4,
        PH_SOF   = 3'd5,
        PH_DONE  = 3'd6
    } phase_t;

    // Dimension byte strobes from the JPEG walker
    typedef struct packed {
        logic h_hi;
        logic h_lo;
        logic w_hi;
        logic w_lo;
    } jpeg_evt_t;

    localparam int SIG_LEN = 12;
    localparam int SKIP_W  = 17;

    // Marker bytes
    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_SOF1   = 8'hC1;
    localparam logic [7:0] MK_SOF2   = 8'hC2;
    localparam logic [7:0] MK_RST_LO = 8'hD0;
    localparam logic [7:0] MK_RST_HI = 8'hD9;
    localparam logic [7:0] MK_TEM    = 8'h01;

    // Signature check over the first twelve bytes, in priority order
    function automatic fmt_t classify(input logic [SIG_LEN-1:0][7:0] s);
        fmt_t f;
        f = FMT_UNKNOWN;
        if (s[0] == 8'h89 && s[1] == 8'h50 && s[2] == 8'h4E && s[3] == 8'h47) begin
            f = FMT_PNG;
        end else if (s[0] == MK_PREFIX && s[1] == MK_SOI && s[2] == MK_PREFIX) begin
            f = FMT_JPEG;
        end else if (s[0] == 8'h47 && s[1] == 8'h49 && s[2] == 8'h46 && s[3] == 8'h38 &&
                     (s[4] == 8'h37 || s[4] == 8'h39) && s[5] == 8'h61) begin
            f = FMT_GIF;
        end else if (s[0] == 8'h52 && s[1] == 8'h49 && s[2] == 8'h46 && s[3] == 8'h46 &&
                     s[8] == 8'h57 && s[9] == 8'h45 && s[10] == 8'h42 &&
                     s[11] == 8'h50) begin
            f = FMT_WEBP;
        end
        return f;
    endfunction

endpackage

@@ rtl/image_header_sniffer.sv @@
// Top level of the image header sniffer: byte stream in, one result per file out.
// Depends on ihs_pkg, ihs_jpeg_walk and ihs_dim_capture.
//
// Takes one file byte per beat and, on the beat flagged last, issues one result
// beat with status, format (PNG, JPEG, GIF, WEBP) and image dimensions. A byte is
// taken every cycle unless input is stalled: the per-byte work is compares and small
// counter updates done between the parser state registers and the result register,
// so the rate is one byte per cycle while not stalled. The result appears in the cycle
// after the last byte is accepted and is held in an output register; input is stalled
// only while that register is full and the result side is not ready. After a result
// all parser state returns to its reset values and the next byte starts a new file.
module image_header_sniffer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ihs_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ihs_pkg::out_beat_t  m_data
);
    import ihs_pkg::*;

    logic       s_accept;
    logic       step_en;
    logic [4:0] pos;
    jpeg_evt_t  evt;
    out_beat_t  result;
    logic       m_valid_reg, m_valid_next;
    out_beat_t  m_data_reg;

    // Input is taken while the result register is free or draining
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign step_en  = s_accept && (pos >= 5'd2);

    ihs_jpeg_walk u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_en   (s_accept),
        .step_en   (step_en),
        .clear     (s_accept && s_data.last),
        .data_byte (s_data.data_byte),
        .evt       (evt)
    );

    ihs_dim_capture u_cap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .beat_en (s_accept),
        .beat    (s_data),
        .evt     (evt),
        .pos     (pos),
        .result  (result)
    );

    // Result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept && s_data.last) m_valid_next = 1'b1;
        else if (m_ready)            m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_data.last) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/ihs_jpeg_walk.sv @@
// JPEG marker walker: tracks segments and flags the SOF dimension bytes.
// Depends on ihs_pkg.
module ihs_jpeg_walk (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 beat_en,
    input  logic                 step_en,
    input  logic                 clear,
    input  logic [7:0]           data_byte,
    output ihs_pkg::jpeg_evt_t   evt
);
    import ihs_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic [7:0]        prev_reg, prev_next;
    logic [15:0]       seg_len;
    logic [SKIP_W-1:0] skip_dec;
    logic [SKIP_W-1:0] skip_inc;

    assign seg_len  = {prev_reg, data_byte};
    assign skip_dec = skip_reg - SKIP_W'(1);
    assign skip_inc = skip_reg + SKIP_W'(1);

    // Next phase and segment counter
    always_comb begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        if (clear) begin
            phase_next = PH_SCAN;
            skip_next  = '0;
        end else if (step_en) begin
            case (phase_reg)
                PH_SCAN: begin
                    if (data_byte == MK_PREFIX) phase_next = PH_MARK;
                end
                PH_MARK: begin
                    if (data_byte == MK_SOF0 || data_byte == MK_SOF1 ||
                        data_byte == MK_SOF2) begin
                        phase_next = PH_SOF;
                        skip_next  = '0;
                    end else if (data_byte == MK_TEM ||
                                 (data_byte >= MK_RST_LO && data_byte <= MK_RST_HI)) begin
                        phase_next = PH_SCAN;
                    end else begin
                        phase_next = PH_LENHI;
                    end
                end
                PH_LENHI: phase_next = PH_LENLO;
                PH_LENLO: begin
                    if (seg_len <= 16'd2) begin
                        phase_next = PH_SCAN;
                    end else begin
                        skip_next  = SKIP_W'(seg_len) - SKIP_W'(2);
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) phase_next = PH_SCAN;
                end
                PH_SOF: begin
                    skip_next = skip_inc;
                    if (skip_inc >= SKIP_W'(7)) phase_next = PH_DONE;
                end
                default: phase_next = PH_DONE;
            endcase
        end
    end

    // Previous byte, feeds the segment length high half
    always_comb begin
        prev_next = prev_reg;
        if (beat_en) prev_next = clear ? 8'h00 : data_byte;
    end

    // Dimension byte strobes: SOF payload bytes 4..7
    always_comb begin
        evt      = '0;
        if (step_en && phase_reg == PH_SOF) begin
            evt.h_hi = (skip_reg == SKIP_W'(3));
            evt.h_lo = (skip_reg == SKIP_W'(4));
            evt.w_hi = (skip_reg == SKIP_W'(5));
            evt.w_lo = (skip_reg == SKIP_W'(6));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SCAN;
            skip_reg  <= '0;
            prev_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            prev_reg  <= prev_next;
        end
    end

endmodule

@@ rtl/ihs_dim_capture.sv @@
// Signature capture, format classification and dimension gathering.
// Depends on ihs_pkg; takes byte strobes from ihs_jpeg_walk.
module ihs_dim_capture (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 beat_en,
    input  ihs_pkg::in_beat_t    beat,
    input  ihs_pkg::jpeg_evt_t   evt,
    output logic [4:0]           pos,
    output ihs_pkg::out_beat_t   result
);
    import ihs_pkg::*;

    logic [4:0]               pos_reg, pos_next;
    logic [SIG_LEN-1:0][7:0]  sig_reg, sig_next;
    logic [31:0]              width_reg, width_next;
    logic [31:0]              height_reg, height_next;
    logic                     found_reg, found_next;
    fmt_t                     fmt;
    logic [7:0]               b;

    assign b   = beat.data_byte;
    assign pos = pos_reg;

    // Signature bytes including the current one
    always_comb begin
        sig_next = sig_reg;
        for (int i = 0; i < SIG_LEN; i++) begin
            if (pos_reg == 5'(i)) sig_next[i] = b;
        end
    end

    assign fmt = classify(sig_next);

    // Dimension field updates per format
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        found_next  = found_reg;
        if (fmt == FMT_PNG && pos_reg >= 5'd16 && pos_reg <= 5'd23) begin
            if (pos_reg <= 5'd19) begin
                width_next = {width_reg[23:0], b};
            end else begin
                height_next = {height_reg[23:0], b};
                if (pos_reg == 5'd23) found_next = 1'b1;
            end
        end else if ((fmt == FMT_GIF && pos_reg >= 5'd6 && pos_reg <= 5'd9) ||
                     (fmt == FMT_WEBP && pos_reg >= 5'd26 && pos_reg <= 5'd29)) begin
            // little-endian 16-bit pair; low two offset bits pick the byte
            case (pos_reg[1:0])
                2'd2:    width_next  = {24'h0, b};
                2'd3:    width_next  = width_reg | {16'h0, b, 8'h0};
                2'd0:    height_next = {24'h0, b};
                default: begin
                    height_next = height_reg | {16'h0, b, 8'h0};
                    found_next  = 1'b1;
                end
            endcase
        end else if (fmt == FMT_JPEG) begin
            if (evt.h_hi) height_next = {16'h0, b, 8'h0};
            if (evt.h_lo) height_next = height_reg | {24'h0, b};
            if (evt.w_hi) width_next  = {16'h0, b, 8'h0};
            if (evt.w_lo) begin
                width_next = width_reg | {24'h0, b};
                found_next = 1'b1;
            end
        end
    end

    // Result for a last beat
    always_comb begin
        if (pos_reg < 5'd7 || fmt == FMT_UNKNOWN) begin
            result.status = 1'b1;
            result.format = FMT_UNKNOWN;
            result.width  = '0;
            result.height = '0;
        end else begin
            result.status = 1'b0;
            result.format = fmt;
            result.width  = found_next ? width_next : '0;
            result.height = found_next ? height_next : '0;
        end
    end

    // Byte offset saturates at 31
    assign pos_next = (pos_reg == 5'd31) ? pos_reg : pos_reg + 5'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            sig_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            found_reg  <= 1'b0;
        end else if (beat_en) begin
            if (beat.last) begin
                pos_reg    <= '0;
                sig_reg    <= '0;
                width_reg  <= '0;
                height_reg <= '0;
                found_reg  <= 1'b0;
            end else begin
                pos_reg    <= pos_next;
                sig_reg    <= sig_next;
                width_reg  <= width_next;
                height_reg <= height_next;
                found_reg  <= found_next;
            end
        end
    end

endmodule

@@ rtl/ihs_checker.sv @@
// Port-level checker for image_header_sniffer, bound to the top level.
// Depends on ihs_pkg and image_header_sniffer_assert.svh.
`include "image_header_sniffer_assert.svh"

module ihs_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input ihs_pkg::in_beat_t   s_data,
    input logic                m_valid,
    input logic                m_ready,
    input ihs_pkg::out_beat_t  m_data
);
    import ihs_pkg::*;

    // Stalled result beat holds
    `IHS_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")

    // New result only right after a last input beat
    `IHS_ASSERT_NOW(a_cause, aclk, aresetn, $rose(m_valid), $past(s_valid && s_ready && s_data.last), "result without a last beat")

    // Error results carry no format or dimensions
    `IHS_ASSERT_NOW(a_err_clean, aclk, aresetn, m_valid && m_data.status, m_data.format == FMT_UNKNOWN && m_data.width == 32'd0 && m_data.height == 32'd0, "error result not cleared")

    // Good results name a known format
    `IHS_ASSERT_NOW(a_ok_fmt, aclk, aresetn, m_valid && !m_data.status, m_data.format == FMT_JPEG || m_data.format == FMT_PNG || m_data.format == FMT_GIF || m_data.format == FMT_WEBP, "ok result with bad format")

endmodule

bind image_header_sniffer ihs_checker u_ihs_checker (.*);
